>>> design/gps_pkg.sv
`timescale 1ns / 1ps

package gps_pkg;

    // value and table geometry
    localparam int VAL_W       = 20;
    localparam int SIEVE_MAX   = 1048576;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int TABLE_WORDS = SIEVE_MAX / (2 * WORD_W);
    localparam int ADDR_W      = $clog2(TABLE_WORDS);

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIEVE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_BOUND = 1'd1;

    localparam logic [VAL_W-1:0] SIEVE_LIMIT_RST = 20'd1048575;
    localparam logic [VAL_W-1:0] PRIME_BOUND_RST = 20'd1000;
    localparam logic [VAL_W-1:0] COUNT_MAX       = 20'hFFFFF;
    localparam logic [VAL_W-1:0] QUERY_MIN       = 20'd6;

    // operation codes
    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             status;
        logic             prime_flag;
        logic             pair_found;
        logic [VAL_W-1:0] smallest_prime;
        logic [VAL_W-1:0] query_total;
        logic [VAL_W-1:0] failure_total;
        logic [VAL_W-1:0] largest_needed;
    } t_rsp;

endpackage

>>> design/gps_ram.sv
`timescale 1ns / 1ps

module gps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/goldbach_pair_sieve_search.sv
`timescale 1ns / 1ps

// Odd-only prime table (one bit per odd number, set = composite) held in a
// 8192 x 64 single-read, single-write RAM, with a small sequencer that builds
// it, tests values and searches Goldbach pairs. One request is worked at a
// time; o_in_ready is high only while the sequencer is idle, and a finished
// response waits in an output register so the next request can be taken.
// The table allows one read per cycle. A clearing pass runs after reset before
// the first request is taken; a prime test reads at most one table word; a
// Goldbach query reads p and then n - p for each odd candidate p tried (from 3
// up to min(prime_bound, n/2)); a build runs a clearing pass, then tests each
// odd base p with p*p <= limit and, for each prime base, reads each multiple
// from p*p on and writes it back marked.
// Configuration writes are taken at any time but must only be made while idle.
module goldbach_pair_sieve_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gps_pkg::VAL_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gps_pkg::t_req                   i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gps_pkg::t_rsp                   o_out_rsp
);

    import gps_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_CLR    = 4'd1;
    localparam logic [ST_W-1:0] S_TRD    = 4'd2;
    localparam logic [ST_W-1:0] S_TWAIT  = 4'd3;
    localparam logic [ST_W-1:0] S_BTEST  = 4'd4;
    localparam logic [ST_W-1:0] S_BTWAIT = 4'd5;
    localparam logic [ST_W-1:0] S_MRD    = 4'd6;
    localparam logic [ST_W-1:0] S_MWR    = 4'd7;
    localparam logic [ST_W-1:0] S_QP     = 4'd8;
    localparam logic [ST_W-1:0] S_QQ     = 4'd9;
    localparam logic [ST_W-1:0] S_QC     = 4'd10;
    localparam logic [ST_W-1:0] S_OUT    = 4'd11;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(TABLE_WORDS - 1);

    // control state
    logic [ST_W-1:0]   r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_clr_build, n_clr_build;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_sieve_limit, r_prime_bound;
    logic [VAL_W-1:0]  r_query_count, n_query_count;
    logic [VAL_W-1:0]  r_failure_count, n_failure_count;
    logic [VAL_W-1:0]  r_largest_p, n_largest_p;

    // working registers
    logic [VAL_W-1:0]  r_v, n_v;
    logic [VAL_W-1:0]  r_p, n_p;
    logic [VAL_W-1:0]  r_top, n_top;
    logic [VAL_W:0]    r_sq, n_sq;
    logic [VAL_W:0]    r_x, n_x;
    logic              r_p_prime, n_p_prime;
    logic              r_status, n_status;
    logic              r_pflag, n_pflag;
    logic              r_found, n_found;
    logic [VAL_W-1:0]  r_smallest, n_smallest;
    t_rsp              r_rsp, n_rsp;

    // table port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [VAL_W-1:0]  q_val;
    logic [VAL_W:0]    lim_w;
    logic [VAL_W:0]    p_next;
    logic [VAL_W:0]    sq_next;
    logic [VAL_W:0]    x_next;
    logic [VAL_W-1:0]  half_v;

    gps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared arithmetic
    assign q_val   = r_v - r_p;
    assign lim_w   = {1'b0, r_sieve_limit};
    assign p_next  = {1'b0, r_p} + (VAL_W+1)'(2);
    assign sq_next = r_sq + (VAL_W+1)'({r_p, 2'b00}) + (VAL_W+1)'(4);
    assign x_next  = r_x + (VAL_W+1)'({r_p, 1'b0});
    assign half_v  = {1'b0, i_in_req.value[VAL_W-1:1]};

    // table read address per state
    always_comb begin
        case (r_state)
            S_TRD:   ram_raddr = r_v[ADDR_W+BIT_W:BIT_W+1];
            S_BTEST: ram_raddr = r_p[ADDR_W+BIT_W:BIT_W+1];
            S_MRD:   ram_raddr = r_x[ADDR_W+BIT_W:BIT_W+1];
            S_QP:    ram_raddr = r_p[ADDR_W+BIT_W:BIT_W+1];
            S_QQ:    ram_raddr = q_val[ADDR_W+BIT_W:BIT_W+1];
            default: ram_raddr = r_p[ADDR_W+BIT_W:BIT_W+1];
        endcase
    end

    // table write: clearing sweep or marking a composite
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        if (r_state == S_CLR) begin
            ram_we = 1'b1;
        end else if (r_state == S_MWR) begin
            ram_we    = 1'b1;
            ram_waddr = r_x[ADDR_W+BIT_W:BIT_W+1];
            ram_wdata = ram_rdata | (WORD_W'(1) << r_x[BIT_W:1]);
        end
    end

    // sequencer
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_clr_build     = r_clr_build;
        n_out_valid     = r_out_valid;
        n_query_count   = r_query_count;
        n_failure_count = r_failure_count;
        n_largest_p     = r_largest_p;
        n_v             = r_v;
        n_p             = r_p;
        n_top           = r_top;
        n_sq            = r_sq;
        n_x             = r_x;
        n_p_prime       = r_p_prime;
        n_status        = r_status;
        n_pflag         = r_pflag;
        n_found         = r_found;
        n_smallest      = r_smallest;
        n_rsp           = r_rsp;

        // response taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_v        = i_in_req.value;
                    n_status   = 1'b0;
                    n_pflag    = 1'b0;
                    n_found    = 1'b0;
                    n_smallest = '0;
                    n_state    = S_OUT;
                    case (i_in_req.opcode)
                        OP_BUILD: begin
                            n_cnt       = '0;
                            n_clr_build = 1'b1;
                            n_state     = S_CLR;
                        end
                        OP_TEST: begin
                            if (i_in_req.value > r_sieve_limit) begin
                                n_status = 1'b1;
                            end else if (i_in_req.value == VAL_W'(2)) begin
                                n_pflag = 1'b1;
                            end else if (i_in_req.value[0]
                                         && i_in_req.value != VAL_W'(1)) begin
                                n_state = S_TRD;
                            end
                        end
                        OP_QUERY: begin
                            if (i_in_req.value[0] || i_in_req.value < QUERY_MIN
                                || i_in_req.value > r_sieve_limit) begin
                                n_status = 1'b1;
                            end else begin
                                if (r_query_count != COUNT_MAX) begin
                                    n_query_count = r_query_count + VAL_W'(1);
                                end
                                n_top = (r_prime_bound < half_v) ? r_prime_bound : half_v;
                                n_p   = VAL_W'(3);
                                // p = 2 never pairs with an even n of 6 or more
                                if (((r_prime_bound < half_v) ? r_prime_bound : half_v)
                                    < VAL_W'(3)) begin
                                    if (r_failure_count != COUNT_MAX) begin
                                        n_failure_count = r_failure_count + VAL_W'(1);
                                    end
                                end else begin
                                    n_state = S_QP;
                                end
                            end
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end

            // clear the whole table, one word a cycle
            S_CLR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_WORD) begin
                    if (r_clr_build) begin
                        n_p     = VAL_W'(3);
                        n_sq    = (VAL_W+1)'(9);
                        n_state = S_BTEST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            // primality test read
            S_TRD: begin
                n_state = S_TWAIT;
            end

            S_TWAIT: begin
                n_pflag = ~ram_rdata[r_v[BIT_W:1]];
                n_state = S_OUT;
            end

            // next sieve base
            S_BTEST: begin
                if (r_sq > lim_w) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_BTWAIT;
                end
            end

            S_BTWAIT: begin
                if (ram_rdata[r_p[BIT_W:1]]) begin
                    n_p     = p_next[VAL_W-1:0];
                    n_sq    = sq_next;
                    n_state = S_BTEST;
                end else begin
                    n_x     = r_sq;
                    n_state = S_MRD;
                end
            end

            // mark multiples: read word, then write it back with the bit set
            S_MRD: begin
                if (r_x > lim_w) begin
                    n_p     = p_next[VAL_W-1:0];
                    n_sq    = sq_next;
                    n_state = S_BTEST;
                end else begin
                    n_state = S_MWR;
                end
            end

            S_MWR: begin
                n_x     = x_next;
                n_state = S_MRD;
            end

            // goldbach candidate: read p, then n - p
            S_QP: begin
                n_state = S_QQ;
            end

            S_QQ: begin
                n_p_prime = ~ram_rdata[r_p[BIT_W:1]];
                n_state   = S_QC;
            end

            S_QC: begin
                if (r_p_prime && !ram_rdata[q_val[BIT_W:1]]) begin
                    n_found    = 1'b1;
                    n_smallest = r_p;
                    if (r_p > r_largest_p) begin
                        n_largest_p = r_p;
                    end
                    n_state = S_OUT;
                end else if (p_next > {1'b0, r_top}) begin
                    if (r_failure_count != COUNT_MAX) begin
                        n_failure_count = r_failure_count + VAL_W'(1);
                    end
                    n_state = S_OUT;
                end else begin
                    n_p     = p_next[VAL_W-1:0];
                    n_state = S_QP;
                end
            end

            // hand the response to the output register
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_rsp.status         = r_status;
                    n_rsp.prime_flag     = r_pflag;
                    n_rsp.pair_found     = r_found;
                    n_rsp.smallest_prime = r_smallest;
                    n_rsp.query_total    = r_query_count;
                    n_rsp.failure_total  = r_failure_count;
                    n_rsp.largest_needed = r_largest_p;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLR;
            r_cnt           <= '0;
            r_clr_build     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_query_count   <= '0;
            r_failure_count <= '0;
            r_largest_p     <= '0;
        end else begin
            r_state         <= n_state;
            r_cnt           <= n_cnt;
            r_clr_build     <= n_clr_build;
            r_out_valid     <= n_out_valid;
            r_query_count   <= n_query_count;
            r_failure_count <= n_failure_count;
            r_largest_p     <= n_largest_p;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sieve_limit <= SIEVE_LIMIT_RST;
            r_prime_bound <= PRIME_BOUND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIEVE_LIMIT: r_sieve_limit <= i_cfg_data;
                CFG_PRIME_BOUND: r_prime_bound <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_p        <= n_p;
        r_top      <= n_top;
        r_sq       <= n_sq;
        r_x        <= n_x;
        r_p_prime  <= n_p_prime;
        r_status   <= n_status;
        r_pflag    <= n_pflag;
        r_found    <= n_found;
        r_smallest <= n_smallest;
        r_rsp      <= n_rsp;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule
